@@ src/hsps_pkg.sv @@
// ----------------------------------------------------------------------------
// hsps_pkg
// Types, codes and constants shared by the sequence parameter set parser.
// ----------------------------------------------------------------------------
package hsps_pkg;

   // default limit on the picture order cycle count
   localparam int DEFAULT_MAX_CYCLE_LEN = 255;

   // header bytes skipped at the start of each set
   localparam logic [1:0] HEADER_BYTES = 2'd3;

   // longest run of leading zeros accepted in a code
   localparam logic [5:0] MAX_ZERO_RUN = 6'd31;

   // frame number size held before it has been read
   localparam logic [4:0] FRAME_BITS_RESET = 5'd4;

   // size fields: offset added to the coded value and saturation point
   localparam logic [4:0] SIZE_OFFSET = 5'd4;
   localparam logic [4:0] SIZE_MAX    = 5'd16;
   localparam logic [31:0] SIZE_CODE_LIMIT = 32'd12;

   // field being parsed
   typedef enum logic [3:0] {
      PH_SET_ID     = 4'd0,
      PH_FRAME_BITS = 4'd1,
      PH_POC_TYPE   = 4'd2,
      PH_POC_BITS   = 4'd3,
      PH_ZERO_FLAG  = 4'd4,
      PH_OFS_NONREF = 4'd5,
      PH_OFS_FIELD  = 4'd6,
      PH_CYCLE_LEN  = 4'd7,
      PH_CYCLE_OFS  = 4'd8,
      PH_REF_COUNT  = 4'd9,
      PH_GAPS       = 4'd10,
      PH_WIDTH      = 4'd11,
      PH_HEIGHT     = 4'd12,
      PH_FRAME_MBS  = 4'd13
   } phase_type;

   // picture order count types
   localparam logic [31:0] ORDER_TYPE_0 = 32'd0;
   localparam logic [31:0] ORDER_TYPE_1 = 32'd1;
   localparam logic [31:0] ORDER_TYPE_2 = 32'd2;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_POC  = 2'd1,
      ST_CODE_ERR = 2'd2
   } status_type;

   // parser state carried from bit to bit and byte to byte
   typedef struct packed {
      logic [1:0]  header_skip;
      phase_type   field_phase;
      logic        code_phase;
      logic [5:0]  zero_count;
      logic [31:0] suffix_value;
      logic [7:0]  cycle_left;
      logic [4:0]  frame_bits;
      logic [1:0]  order_type;
      logic [4:0]  poc_bits;
      logic        finished;
   } parse_state_type;

   // result raised by a bit step
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       mbs;
   } bit_result_type;

   // one byte's outcome handed to the output register
   typedef struct packed {
      logic       valid;
      status_type status;
      logic [4:0] frame_bits;
      logic [1:0] order_type;
      logic [4:0] poc_lsb;
      logic       mbs;
   } step_out_type;

   // state at the start of every set
   localparam parse_state_type CLEAR_STATE = '{
      header_skip:  2'd0,
      field_phase:  PH_SET_ID,
      code_phase:   1'b0,
      zero_count:   6'd0,
      suffix_value: 32'd0,
      cycle_left:   8'd0,
      frame_bits:   FRAME_BITS_RESET,
      order_type:   2'(ORDER_TYPE_0),
      poc_bits:     5'd0,
      finished:     1'b0
   };

   // state after reset: idle until a start request
   localparam parse_state_type IDLE_STATE = '{
      header_skip:  2'd0,
      field_phase:  PH_SET_ID,
      code_phase:   1'b0,
      zero_count:   6'd0,
      suffix_value: 32'd0,
      cycle_left:   8'd0,
      frame_bits:   FRAME_BITS_RESET,
      order_type:   2'(ORDER_TYPE_0),
      poc_bits:     5'd0,
      finished:     1'b1
   };

   // size field: coded value plus four, saturated
   function automatic logic [4:0] size_sat(input logic [31:0] v);
      logic [4:0] r;
      if (v > SIZE_CODE_LIMIT) begin
         r = SIZE_MAX;
      end else begin
         r = 5'(v[4:0] + SIZE_OFFSET);
      end
      return r;
   endfunction

endpackage

@@ src/hsps_bit_step.sv @@
// ----------------------------------------------------------------------------
// hsps_bit_step
// One bit of the parse: exp-Golomb decoding, flag bits and field sequencing.
// ----------------------------------------------------------------------------
module hsps_bit_step #(
   parameter int MAX_CYCLE_LEN = hsps_pkg::DEFAULT_MAX_CYCLE_LEN
) (
   input  hsps_pkg::parse_state_type cur,
   input  hsps_pkg::bit_result_type  res_in,
   input  logic                      bit_in,
   output hsps_pkg::parse_state_type nxt,
   output hsps_pkg::bit_result_type  res_out
);
   import hsps_pkg::*;

   logic        done_code;
   logic [31:0] code_val;
   logic [31:0] sfx_shift;
   logic [5:0]  zc_dec;
   logic [7:0]  cl_dec;

   always_comb begin
      nxt       = cur;
      res_out   = res_in;
      done_code = 1'b0;
      code_val  = '0;
      sfx_shift = {cur.suffix_value[30:0], bit_in};
      zc_dec    = 6'(cur.zero_count - 6'd1);
      cl_dec    = 8'(cur.cycle_left - 8'd1);

      if (!cur.finished) begin
         // bit handling by field
         case (cur.field_phase)
            PH_ZERO_FLAG: nxt.field_phase = PH_OFS_NONREF;
            PH_GAPS:      nxt.field_phase = PH_WIDTH;
            PH_FRAME_MBS: begin
               res_out.valid  = 1'b1;
               res_out.status = ST_OK;
               res_out.mbs    = bit_in;
               nxt.finished   = 1'b1;
            end
            PH_SET_ID, PH_FRAME_BITS, PH_POC_TYPE, PH_POC_BITS, PH_OFS_NONREF,
            PH_OFS_FIELD, PH_CYCLE_LEN, PH_CYCLE_OFS, PH_REF_COUNT, PH_WIDTH,
            PH_HEIGHT: begin
               if (!cur.code_phase) begin
                  // leading zero count
                  if (!bit_in) begin
                     if (cur.zero_count >= MAX_ZERO_RUN) begin
                        res_out.valid  = 1'b1;
                        res_out.status = ST_CODE_ERR;
                        res_out.mbs    = 1'b0;
                        nxt.finished   = 1'b1;
                     end else begin
                        nxt.zero_count = 6'(cur.zero_count + 6'd1);
                     end
                  end else if (cur.zero_count == 6'd0) begin
                     done_code = 1'b1;
                  end else begin
                     nxt.suffix_value = 32'd1;
                     nxt.code_phase   = 1'b1;
                  end
               end else begin
                  // suffix bits
                  nxt.suffix_value = sfx_shift;
                  nxt.zero_count   = zc_dec;
                  if (zc_dec == 6'd0) begin
                     nxt.code_phase = 1'b0;
                     done_code      = 1'b1;
                     code_val       = sfx_shift - 32'd1;
                  end
               end
            end
            default: nxt.finished = 1'b1;
         endcase

         // completed code moves to the next field
         if (done_code) begin
            case (cur.field_phase)
               PH_SET_ID: nxt.field_phase = PH_FRAME_BITS;
               PH_FRAME_BITS: begin
                  nxt.frame_bits  = size_sat(code_val);
                  nxt.field_phase = PH_POC_TYPE;
               end
               PH_POC_TYPE: begin
                  if (code_val == ORDER_TYPE_0) begin
                     nxt.order_type  = 2'(ORDER_TYPE_0);
                     nxt.field_phase = PH_POC_BITS;
                  end else if (code_val == ORDER_TYPE_1) begin
                     nxt.order_type  = 2'(ORDER_TYPE_1);
                     nxt.field_phase = PH_ZERO_FLAG;
                  end else if (code_val == ORDER_TYPE_2) begin
                     nxt.order_type  = 2'(ORDER_TYPE_2);
                     nxt.field_phase = PH_REF_COUNT;
                  end else begin
                     res_out.valid  = 1'b1;
                     res_out.status = ST_BAD_POC;
                     res_out.mbs    = 1'b0;
                     nxt.finished   = 1'b1;
                  end
               end
               PH_POC_BITS: begin
                  nxt.poc_bits    = size_sat(code_val);
                  nxt.field_phase = PH_REF_COUNT;
               end
               PH_OFS_NONREF: nxt.field_phase = PH_OFS_FIELD;
               PH_OFS_FIELD:  nxt.field_phase = PH_CYCLE_LEN;
               PH_CYCLE_LEN: begin
                  if (code_val > 32'(MAX_CYCLE_LEN)) begin
                     res_out.valid  = 1'b1;
                     res_out.status = ST_CODE_ERR;
                     res_out.mbs    = 1'b0;
                     nxt.finished   = 1'b1;
                  end else begin
                     nxt.cycle_left  = code_val[7:0];
                     nxt.field_phase = (code_val != 32'd0) ? PH_CYCLE_OFS : PH_REF_COUNT;
                  end
               end
               PH_CYCLE_OFS: begin
                  nxt.cycle_left = cl_dec;
                  if (cl_dec == 8'd0) begin
                     nxt.field_phase = PH_REF_COUNT;
                  end
               end
               PH_REF_COUNT: nxt.field_phase = PH_GAPS;
               PH_WIDTH:     nxt.field_phase = PH_HEIGHT;
               PH_HEIGHT:    nxt.field_phase = PH_FRAME_MBS;
               default:      nxt.finished    = 1'b1;
            endcase
         end
      end
   end

endmodule

@@ src/hsps_parse_core.sv @@
// ----------------------------------------------------------------------------
// hsps_parse_core
// Parser state register and the eight-bit chain that consumes one byte.
// ----------------------------------------------------------------------------
module hsps_parse_core #(
   parameter int MAX_CYCLE_LEN = hsps_pkg::DEFAULT_MAX_CYCLE_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [7:0]            data_byte,
   input  logic                  start_req,
   output hsps_pkg::step_out_type step_out
);
   import hsps_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type entry_state;
   parse_state_type chain_state [0:8];
   bit_result_type  chain_res   [0:8];

   // start request clears the set in progress
   always_comb begin
      entry_state = state_ff;
      if (start_req) begin
         entry_state = CLEAR_STATE;
      end
   end

   // bit chain, most significant bit first
   assign chain_state[0] = entry_state;
   assign chain_res[0]   = '{valid: 1'b0, status: ST_OK, mbs: 1'b0};

   for (genvar i = 0; i < 8; i++) begin : g_bit
      hsps_bit_step #(
         .MAX_CYCLE_LEN(MAX_CYCLE_LEN)
      ) u_bit (
         .cur    (chain_state[i]),
         .res_in (chain_res[i]),
         .bit_in (data_byte[7 - i]),
         .nxt    (chain_state[i + 1]),
         .res_out(chain_res[i + 1])
      );
   end

   // choose idle, header skip or parsed byte
   always_comb begin
      state_in       = entry_state;
      step_out.valid = 1'b0;
      step_out.status = ST_OK;
      step_out.mbs   = 1'b0;
      if (!entry_state.finished) begin
         if (entry_state.header_skip < HEADER_BYTES) begin
            state_in.header_skip = 2'(entry_state.header_skip + 2'd1);
         end else begin
            state_in        = chain_state[8];
            step_out.valid  = chain_res[8].valid;
            step_out.status = chain_res[8].status;
            step_out.mbs    = chain_res[8].mbs;
         end
      end
      step_out.frame_bits = state_in.frame_bits;
      step_out.order_type = state_in.order_type;
      step_out.poc_lsb    = (state_in.order_type == 2'(ORDER_TYPE_0)) ?
                            state_in.poc_bits : 5'd0;
   end

   // parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_STATE;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/h264_sps_header_parser.sv @@
// ----------------------------------------------------------------------------
// h264_sps_header_parser
// Sequence parameter set header parser with registered input and result.
// ----------------------------------------------------------------------------
// Takes one payload byte per transaction and accepts a new byte every clock
// cycle while req_stall is low. A byte with req_start_req high begins a new
// set; the first three bytes of a set are skipped. Each byte is parsed by
// eight chained bit steps between the input register and the parser state
// register, and a result is registered in the result register that drives
// rsp_valid. After reset the block ignores bytes until a start. At most one
// result is produced per set; rsp_stall holds the result register and, once
// the input register is also full, req_stall.
module h264_sps_header_parser #(
   parameter int MAX_CYCLE_LEN = hsps_pkg::DEFAULT_MAX_CYCLE_LEN
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_start_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_log2_max_frame_num,
   output logic [1:0] rsp_order_type,
   output logic [4:0] rsp_log2_max_poc_lsb,
   output logic       rsp_frame_mbs_only
);
   import hsps_pkg::*;

   logic         in_valid_ff;
   logic         in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_start_ff;
   logic         advance;
   logic         req_take;
   step_out_type step_out;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   step_out_type rsp_ff;

   // input stage moves on when the result register can take a transaction
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_start_req;
      end
   end

   // byte parser
   hsps_parse_core #(
      .MAX_CYCLE_LEN(MAX_CYCLE_LEN)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .data_byte(in_byte_ff),
      .start_req(in_start_ff),
      .step_out (step_out)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && step_out.valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_out.valid) begin
         rsp_ff <= step_out;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_ff.status;
   assign rsp_log2_max_frame_num = rsp_ff.frame_bits;
   assign rsp_order_type         = rsp_ff.order_type;
   assign rsp_log2_max_poc_lsb   = rsp_ff.poc_lsb;
   assign rsp_frame_mbs_only     = rsp_ff.mbs;

endmodule
